// ----- design/gsu_pkg.sv -----
`default_nettype none
package gsu_pkg;

  localparam int POS_BITS_DEF = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // item kinds
  localparam logic [2:0] ACT_GOAL = 3'd0;
  localparam logic [2:0] ACT_ODOM = 3'd1;
  localparam logic [2:0] ACT_TICK = 3'd2;
  localparam logic [2:0] ACT_CMD  = 3'd3;
  localparam logic [2:0] ACT_ACK  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_HEAD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd4;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_NAV  = 2'd1;
  localparam logic [1:0] MODE_HOLD = 2'd2;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // 0.1 m squared and 0.1 rad in fixed point
  localparam logic [31:0]        GOAL_MOVE_SQ  = 32'd10485;
  localparam logic signed [16:0] GOAL_TURN     = 17'sd1043;
  localparam logic signed [16:0] GOAL_TURN_NEG = -17'sd1043;

  // reset values, distances kept as squares
  localparam logic [31:0] ARRIVE_SQ_RST   = 32'd42025;
  localparam logic [14:0] ARRIVE_HEAD_RST = 15'd1565;
  localparam logic [14:0] STOP_SPEED_RST  = 15'd51;
  localparam logic [31:0] DRIFT_SQ_RST    = 32'd65536;
  localparam logic [15:0] SETTLE_RST      = 16'd20;

  typedef struct packed {
    logic [31:0] arrive_sq;
    logic [14:0] arrive_head;
    logic [14:0] stop_speed;
    logic [31:0] drift_sq;
    logic [15:0] settle_ticks;
  } gsu_cfg_t;

  typedef struct packed {
    logic               cmd_valid;
    logic signed [15:0] cmd_linear;
    logic signed [15:0] cmd_angular;
    logic [1:0]         mode;
    logic               mode_changed;
    logic [1:0]         switch_request;
    logic               drive_enabled;
  } gsu_result_t;

endpackage
`default_nettype wire

// ----- design/gsu_cfg.sv -----
`default_nettype none
module gsu_cfg import gsu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output gsu_cfg_t              cfg
);

  gsu_cfg_t    cfg_r;
  logic [31:0] wdata_sq;

  // distance limits are stored squared, computed on the write
  assign wdata_sq = {16'd0, cfg_wdata} * {16'd0, cfg_wdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arrive_sq    <= ARRIVE_SQ_RST;
      cfg_r.arrive_head  <= ARRIVE_HEAD_RST;
      cfg_r.stop_speed   <= STOP_SPEED_RST;
      cfg_r.drift_sq     <= DRIFT_SQ_RST;
      cfg_r.settle_ticks <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARRIVE_DIST: cfg_r.arrive_sq    <= wdata_sq;
        REG_ARRIVE_HEAD: cfg_r.arrive_head  <= cfg_wdata[14:0];
        REG_STOP_SPEED:  cfg_r.stop_speed   <= cfg_wdata[14:0];
        REG_DRIFT_LIMIT: cfg_r.drift_sq     <= wdata_sq;
        REG_SETTLE:      cfg_r.settle_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- design/gsu_core.sv -----
`default_nettype none
module gsu_core import gsu_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [2:0]                 action,
  input  logic signed [POS_BITS-1:0] pos_x,
  input  logic signed [POS_BITS-1:0] pos_y,
  input  logic signed [15:0]         heading,
  input  logic signed [15:0]         linear_speed,
  input  logic signed [15:0]         turn_rate,
  input  logic                       switch_ok,
  input  gsu_cfg_t                   cfg,
  output gsu_result_t                res
);

  localparam int DW = POS_BITS + 1;
  localparam int SW = (DW < 31) ? DW : 31;
  localparam int QW = 2 * SW + 1;

  logic                       goal_known_r, goal_known_nxt;
  logic                       holding_r, holding_nxt;
  logic                       drives_on_r, drives_on_nxt;
  logic [1:0]                 mode_r, mode_nxt;
  logic signed [POS_BITS-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic signed [15:0]         tgt_yaw_r, tgt_yaw_nxt;
  logic signed [POS_BITS-1:0] veh_x_r, veh_x_nxt, veh_y_r, veh_y_nxt;
  logic signed [15:0]         veh_yaw_r, veh_yaw_nxt, veh_spd_r, veh_spd_nxt;
  logic signed [POS_BITS-1:0] anc_x_r, anc_x_nxt, anc_y_r, anc_y_nxt;
  logic [15:0]                hold_cnt_r, hold_cnt_nxt;
  logic                       pend_tgt_r, pend_tgt_nxt, pend_vld_r, pend_vld_nxt;

  // shared squared-distance unit
  logic signed [POS_BITS-1:0] pa_x, pa_y, pb_x, pb_y;
  logic signed [DW-1:0]       diff_x, diff_y;
  logic [DW-1:0]              mag_x, mag_y;
  logic [SW-1:0]              sx, sy;
  logic [2*SW-1:0]            sq_x, sq_y;
  logic [QW-1:0]              dist_sq;
  logic                       dist_sat;
  logic                       goal_far, near_goal, drifted;

  logic signed [16:0]         dyaw;
  logic                       goal_turned, goal_new;
  logic [15:0]                herr;
  logic [16:0]                herr_mag, spd_mag;
  logic                       aligned, stopped;
  logic [15:0]                hold_inc;
  logic                       req_fire, req_on;

  always_comb begin
    if (action == ACT_GOAL) begin
      pa_x = pos_x;   pa_y = pos_y;   pb_x = tgt_x_r; pb_y = tgt_y_r;
    end else if (holding_r) begin
      pa_x = veh_x_r; pa_y = veh_y_r; pb_x = anc_x_r; pb_y = anc_y_r;
    end else begin
      pa_x = tgt_x_r; pa_y = tgt_y_r; pb_x = veh_x_r; pb_y = veh_y_r;
    end
  end

  assign diff_x   = {pa_x[POS_BITS-1], pa_x} - {pb_x[POS_BITS-1], pb_x};
  assign diff_y   = {pa_y[POS_BITS-1], pa_y} - {pb_y[POS_BITS-1], pb_y};
  assign mag_x    = diff_x[DW-1] ? -diff_x : diff_x;
  assign mag_y    = diff_y[DW-1] ? -diff_y : diff_y;
  // differences of 2^31 or more count as infinitely far
  assign dist_sat = ((mag_x >> 31) != '0) || ((mag_y >> 31) != '0);
  assign sx       = mag_x[SW-1:0];
  assign sy       = mag_y[SW-1:0];
  assign sq_x     = sx * sx;
  assign sq_y     = sy * sy;
  assign dist_sq  = {1'b0, sq_x} + {1'b0, sq_y};

  assign goal_far  = dist_sat || (dist_sq > {{(QW-32){1'b0}}, GOAL_MOVE_SQ});
  assign near_goal = !dist_sat && (dist_sq < {{(QW-32){1'b0}}, cfg.arrive_sq});
  assign drifted   = dist_sat || (dist_sq > {{(QW-32){1'b0}}, cfg.drift_sq});

  // goal yaw compared without wrapping
  assign dyaw        = {heading[15], heading} - {tgt_yaw_r[15], tgt_yaw_r};
  assign goal_turned = (dyaw > GOAL_TURN) || (dyaw < GOAL_TURN_NEG);
  assign goal_new    = !goal_known_r || goal_far || goal_turned;

  // arrival heading error wraps, half a turn gives 32768
  assign herr     = tgt_yaw_r - veh_yaw_r;
  assign herr_mag = herr[15] ? (17'h10000 - {1'b0, herr}) : {1'b0, herr};
  assign spd_mag  = veh_spd_r[15] ? (17'h10000 - {1'b0, veh_spd_r}) : {1'b0, veh_spd_r};
  assign aligned  = herr_mag < {2'b00, cfg.arrive_head};
  assign stopped  = spd_mag < {2'b00, cfg.stop_speed};

  assign hold_inc = (hold_cnt_r != 16'hFFFF) ? (hold_cnt_r + 16'd1) : hold_cnt_r;

  always_comb begin
    goal_known_nxt = goal_known_r;
    holding_nxt    = holding_r;
    drives_on_nxt  = drives_on_r;
    mode_nxt       = mode_r;
    tgt_x_nxt      = tgt_x_r;
    tgt_y_nxt      = tgt_y_r;
    tgt_yaw_nxt    = tgt_yaw_r;
    veh_x_nxt      = veh_x_r;
    veh_y_nxt      = veh_y_r;
    veh_yaw_nxt    = veh_yaw_r;
    veh_spd_nxt    = veh_spd_r;
    anc_x_nxt      = anc_x_r;
    anc_y_nxt      = anc_y_r;
    hold_cnt_nxt   = hold_cnt_r;
    pend_tgt_nxt   = pend_tgt_r;
    pend_vld_nxt   = pend_vld_r;
    req_fire       = 1'b0;
    req_on         = 1'b0;
    res.cmd_valid   = 1'b0;
    res.cmd_linear  = '0;
    res.cmd_angular = '0;

    case (action)
      ACT_GOAL: begin
        if (goal_new) begin
          tgt_x_nxt      = pos_x;
          tgt_y_nxt      = pos_y;
          tgt_yaw_nxt    = heading;
          goal_known_nxt = 1'b1;
          if (holding_r) begin
            holding_nxt = 1'b0;
            req_fire    = 1'b1;
            req_on      = 1'b1;
            mode_nxt    = MODE_NAV;
          end
        end
      end
      ACT_ODOM: begin
        veh_x_nxt   = pos_x;
        veh_y_nxt   = pos_y;
        veh_yaw_nxt = heading;
        veh_spd_nxt = linear_speed;
      end
      ACT_TICK: begin
        if (goal_known_r) begin
          if (!holding_r) begin
            if (near_goal && aligned && stopped) begin
              holding_nxt  = 1'b1;
              anc_x_nxt    = veh_x_r;
              anc_y_nxt    = veh_y_r;
              hold_cnt_nxt = '0;
              mode_nxt     = MODE_HOLD;
            end
          end else if (drifted) begin
            holding_nxt = 1'b0;
            req_fire    = 1'b1;
            req_on      = 1'b1;
            mode_nxt    = MODE_NAV;
          end else begin
            hold_cnt_nxt = hold_inc;
            if (drives_on_r && (hold_inc > cfg.settle_ticks)) begin
              req_fire = 1'b1;
              req_on   = 1'b0;
            end
          end
        end
      end
      ACT_CMD: begin
        res.cmd_valid = 1'b1;
        if (!holding_r) begin
          res.cmd_linear  = linear_speed;
          res.cmd_angular = turn_rate;
        end
      end
      ACT_ACK: begin
        if (pend_vld_r) begin
          if (switch_ok) drives_on_nxt = pend_tgt_r;
          pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // a request goes out only if it changes something not already pending
    res.switch_request = REQ_NONE;
    if (req_fire && (drives_on_r != req_on) && !(pend_vld_r && (pend_tgt_r == req_on))) begin
      pend_vld_nxt       = 1'b1;
      pend_tgt_nxt       = req_on;
      res.switch_request = req_on ? REQ_START : REQ_STOP;
    end

    res.mode          = mode_nxt;
    res.mode_changed  = (mode_nxt != mode_r);
    res.drive_enabled = drives_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_known_r <= 1'b0;
      holding_r    <= 1'b0;
      drives_on_r  <= 1'b1;
      mode_r       <= MODE_INIT;
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      tgt_yaw_r    <= '0;
      veh_x_r      <= '0;
      veh_y_r      <= '0;
      veh_yaw_r    <= '0;
      veh_spd_r    <= '0;
      anc_x_r      <= '0;
      anc_y_r      <= '0;
      hold_cnt_r   <= '0;
      pend_tgt_r   <= 1'b0;
      pend_vld_r   <= 1'b0;
    end else if (step) begin
      goal_known_r <= goal_known_nxt;
      holding_r    <= holding_nxt;
      drives_on_r  <= drives_on_nxt;
      mode_r       <= mode_nxt;
      tgt_x_r      <= tgt_x_nxt;
      tgt_y_r      <= tgt_y_nxt;
      tgt_yaw_r    <= tgt_yaw_nxt;
      veh_x_r      <= veh_x_nxt;
      veh_y_r      <= veh_y_nxt;
      veh_yaw_r    <= veh_yaw_nxt;
      veh_spd_r    <= veh_spd_nxt;
      anc_x_r      <= anc_x_nxt;
      anc_y_r      <= anc_y_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      pend_tgt_r   <= pend_tgt_nxt;
      pend_vld_r   <= pend_vld_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/goal_hold_supervisor_unit.sv -----
// Goal-hold supervisor for a wheeled vehicle.
// Input channel (in_valid/in_ready) carries one transaction per event: a goal,
// an odometry sample, a supervisor tick, a velocity command or a controller
// switch acknowledgement. Every input transaction yields exactly one result
// transaction on the output channel (out_valid/out_ready) with the forwarded
// command, the reported mode and any controller start/stop request.
// Configuration (cfg_we/cfg_index/cfg_wdata) is to be written only while the
// block is idle; the block itself does not enforce this. Distance limits are
// squared as they are written. An accepted transaction is held in the input
// register and its result is registered in the result register. Throughput:
// one transaction per cycle while out_ready keeps up; the whole update, including the
// shared squared-distance multiplier pair, is combinational between the registers.
// Stalls: when a valid result waits with out_ready low, the result register holds,
// and the input register still takes one more transaction before in_ready drops.
// Reset (rst_n low at a clock edge) empties both registers, restores the
// register defaults, forgets the goal, leaves hold and marks drives enabled.
`default_nettype none
module goal_hold_supervisor_unit import gsu_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 in_action,
  input  logic signed [POS_BITS-1:0] in_pos_x,
  input  logic signed [POS_BITS-1:0] in_pos_y,
  input  logic signed [15:0]         in_heading,
  input  logic signed [15:0]         in_linear_speed,
  input  logic signed [15:0]         in_turn_rate,
  input  logic                       in_switch_ok,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_cmd_valid,
  output logic signed [15:0]         out_cmd_linear,
  output logic signed [15:0]         out_cmd_angular,
  output logic [1:0]                 out_mode,
  output logic                       out_mode_changed,
  output logic [1:0]                 out_switch_request,
  output logic                       out_drive_enabled
);

  gsu_cfg_t    cfg;
  gsu_result_t res, res_r;

  logic                       in_vld_r, in_vld_nxt;
  logic                       out_vld_r, out_vld_nxt;
  logic                       advance, step, in_take;
  logic [2:0]                 action_r;
  logic signed [POS_BITS-1:0] pos_x_r, pos_y_r;
  logic signed [15:0]         heading_r, lin_r, turn_r;
  logic                       ok_r;

  assign advance  = !out_vld_r || out_ready;
  assign step     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_r);
    out_vld_nxt = advance ? in_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r  <= in_action;
      pos_x_r   <= in_pos_x;
      pos_y_r   <= in_pos_y;
      heading_r <= in_heading;
      lin_r     <= in_linear_speed;
      turn_r    <= in_turn_rate;
      ok_r      <= in_switch_ok;
    end
    if (step) res_r <= res;
  end

  gsu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gsu_core #(.POS_BITS(POS_BITS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .action       (action_r),
    .pos_x        (pos_x_r),
    .pos_y        (pos_y_r),
    .heading      (heading_r),
    .linear_speed (lin_r),
    .turn_rate    (turn_r),
    .switch_ok    (ok_r),
    .cfg          (cfg),
    .res          (res)
  );

  assign out_valid          = out_vld_r;
  assign out_cmd_valid      = res_r.cmd_valid;
  assign out_cmd_linear     = res_r.cmd_linear;
  assign out_cmd_angular    = res_r.cmd_angular;
  assign out_mode           = res_r.mode;
  assign out_mode_changed   = res_r.mode_changed;
  assign out_switch_request = res_r.switch_request;
  assign out_drive_enabled  = res_r.drive_enabled;

endmodule
`default_nettype wire

// ----- design/gsu_checker.sv -----
`default_nettype none
module gsu_checker import gsu_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_cmd_valid,
  input logic signed [15:0] out_cmd_linear,
  input logic signed [15:0] out_cmd_angular,
  input logic [1:0]         out_mode,
  input logic               out_mode_changed,
  input logic [1:0]         out_switch_request,
  input logic               out_drive_enabled
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_cmd_valid, out_cmd_linear,
      out_cmd_angular, out_mode, out_mode_changed, out_switch_request, out_drive_enabled}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a start request is only issued while drives are believed off
  a_start_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_switch_request == REQ_START) |-> !out_drive_enabled)
    else $error("start requested with drives enabled");

  // mode never falls back to init, and commands never change it
  a_mode_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_changed |-> (out_mode != MODE_INIT) && !out_cmd_valid)
    else $error("bad mode change");

endmodule

bind goal_hold_supervisor_unit gsu_checker u_gsu_checker (.*);
`default_nettype wire

// ----- verif/hold_supervisor_checker.sv -----
module hold_supervisor_checker import gsu_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [2:0]                     in_action,
  input  logic signed [POS_BITS_DEF-1:0] in_pos_x,
  input  logic signed [POS_BITS_DEF-1:0] in_pos_y,
  input  logic signed [15:0]             in_heading,
  input  logic signed [15:0]             in_linear_speed,
  input  logic signed [15:0]             in_turn_rate,
  input  logic                           in_switch_ok,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_cmd_valid,
  input  logic signed [15:0]             out_cmd_linear,
  input  logic signed [15:0]             out_cmd_angular,
  input  logic [1:0]                     out_mode,
  input  logic                           out_mode_changed,
  input  logic [1:0]                     out_switch_request,
  input  logic                           out_drive_enabled,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int PW = POS_BITS_DEF;
  // 0.1 m squared and 0.1 rad
  localparam longint unsigned GOAL_SHIFT_SQ = 64'd10485;
  localparam int GOAL_TURN_LIM = 1043;

  logic [15:0] arrive_dist, drift_lim, settle_lim;
  logic [14:0] arrive_head, stop_spd;
  logic goal_known, holding, drives_on, pend_on, pend_valid;
  logic [1:0] mode_now;
  logic signed [PW-1:0] goal_px, goal_py, veh_px, veh_py, anchor_px, anchor_py;
  logic signed [15:0] goal_hd, veh_hd, veh_spd;
  logic [15:0] hold_ticks;
  gsu_result_t results_due[$];

  function automatic longint unsigned sq_dist(input logic signed [PW-1:0] ax, ay, bx, by);
    longint dx, dy;
    longint unsigned mx, my;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) return '1;
    return mx * mx + my * my;
  endfunction

  // issue a start/stop only when it changes something and is not already pending
  function automatic logic [1:0] ask_drives(input logic on);
    if (drives_on == on) return REQ_NONE;
    if (pend_valid && pend_on == on) return REQ_NONE;
    pend_valid = 1'b1;
    pend_on = on;
    return on ? REQ_START : REQ_STOP;
  endfunction

  function automatic gsu_result_t predict_item(
      input logic [2:0] act, input logic signed [PW-1:0] px, py,
      input logic signed [15:0] hd, lin, ang, input logic ok);
    gsu_result_t r;
    logic [1:0] prev_mode;
    int yaw_step;
    logic signed [15:0] yaw_err;
    int unsigned yaw_mag, spd_mag;
    longint unsigned lim;
    r = '0;
    prev_mode = mode_now;
    case (act)
      ACT_GOAL: begin
        yaw_step = int'(hd) - int'(goal_hd);
        if (!goal_known || sq_dist(px, py, goal_px, goal_py) > GOAL_SHIFT_SQ ||
            yaw_step > GOAL_TURN_LIM || yaw_step < -GOAL_TURN_LIM) begin
          goal_px = px;
          goal_py = py;
          goal_hd = hd;
          goal_known = 1'b1;
          if (holding) begin
            holding = 1'b0;
            r.switch_request = ask_drives(1'b1);
            mode_now = MODE_NAV;
          end
        end
      end
      ACT_ODOM: begin
        veh_px = px;
        veh_py = py;
        veh_hd = hd;
        veh_spd = lin;
      end
      ACT_TICK: if (goal_known) begin
        if (!holding) begin
          // heading error wraps to 16 bits
          yaw_err = goal_hd - veh_hd;
          yaw_mag = (yaw_err < 0) ? -int'(yaw_err) : int'(yaw_err);
          spd_mag = (veh_spd < 0) ? -int'(veh_spd) : int'(veh_spd);
          lim = arrive_dist;
          lim = lim * lim;
          if (sq_dist(goal_px, goal_py, veh_px, veh_py) < lim &&
              yaw_mag < arrive_head && spd_mag < stop_spd) begin
            holding = 1'b1;
            anchor_px = veh_px;
            anchor_py = veh_py;
            hold_ticks = '0;
            mode_now = MODE_HOLD;
          end
        end else begin
          lim = drift_lim;
          lim = lim * lim;
          if (sq_dist(veh_px, veh_py, anchor_px, anchor_py) > lim) begin
            holding = 1'b0;
            r.switch_request = ask_drives(1'b1);
            mode_now = MODE_NAV;
          end else begin
            if (hold_ticks != 16'hFFFF) hold_ticks++;
            if (drives_on && hold_ticks > settle_lim) r.switch_request = ask_drives(1'b0);
          end
        end
      end
      ACT_CMD: begin
        r.cmd_valid = 1'b1;
        if (!holding) begin
          r.cmd_linear = lin;
          r.cmd_angular = ang;
        end
      end
      ACT_ACK: if (pend_valid) begin
        if (ok) drives_on = pend_on;
        pend_valid = 1'b0;
      end
      default: ;
    endcase
    r.mode = mode_now;
    r.mode_changed = (mode_now != prev_mode);
    r.drive_enabled = drives_on;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    gsu_result_t want;
    if (!rst_n) begin
      // register defaults
      arrive_dist = 16'd205;
      arrive_head = 15'd1565;
      stop_spd = 15'd51;
      drift_lim = 16'd256;
      settle_lim = 16'd20;
      goal_known = 1'b0;
      holding = 1'b0;
      drives_on = 1'b1;
      pend_on = 1'b0;
      pend_valid = 1'b0;
      mode_now = MODE_INIT;
      goal_px = '0;
      goal_py = '0;
      goal_hd = '0;
      veh_px = '0;
      veh_py = '0;
      veh_hd = '0;
      veh_spd = '0;
      anchor_px = '0;
      anchor_py = '0;
      hold_ticks = '0;
      mismatches = 0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ARRIVE_DIST: arrive_dist = cfg_wdata;
          REG_ARRIVE_HEAD: arrive_head = cfg_wdata[14:0];
          REG_STOP_SPEED:  stop_spd = cfg_wdata[14:0];
          REG_DRIFT_LIMIT: drift_lim = cfg_wdata;
          REG_SETTLE:      settle_lim = cfg_wdata;
          default: ;
        endcase
      end
      // pop before push so a result never matches a transaction of the same edge
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = results_due.pop_front();
          check_field("cmd_valid", out_cmd_valid, want.cmd_valid);
          check_field("cmd_linear", out_cmd_linear, want.cmd_linear);
          check_field("cmd_angular", out_cmd_angular, want.cmd_angular);
          check_field("mode", out_mode, want.mode);
          check_field("mode_changed", out_mode_changed, want.mode_changed);
          check_field("switch_request", out_switch_request, want.switch_request);
          check_field("drive_enabled", out_drive_enabled, want.drive_enabled);
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(predict_item(in_action, in_pos_x, in_pos_y, in_heading,
                                           in_linear_speed, in_turn_rate, in_switch_ok));
      end
    end
    outstanding <= results_due.size();
  end

endmodule

// ----- verif/goal_hold_supervisor_unit_test.sv -----
module goal_hold_supervisor_unit_test;
  import gsu_pkg::*;

  localparam int PW = POS_BITS_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SEGMENTS = 3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SEND_IDLE[3] = '{33, 45, 0};
  localparam int RECV_IDLE[3] = '{45, 33, 0};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_action;
  logic signed [PW-1:0]  in_pos_x;
  logic signed [PW-1:0]  in_pos_y;
  logic signed [15:0]    in_heading;
  logic signed [15:0]    in_linear_speed;
  logic signed [15:0]    in_turn_rate;
  logic                  in_switch_ok;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_cmd_valid;
  logic signed [15:0]    out_cmd_linear;
  logic signed [15:0]    out_cmd_angular;
  logic [1:0]            out_mode;
  logic                  out_mode_changed;
  logic [1:0]            out_switch_request;
  logic                  out_drive_enabled;

  int mismatches, outstanding;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  int items_sent;
  int set_arrive, set_head, set_stop, set_drift, set_settle;
  int goal_x, goal_y, goal_yaw;

  goal_hold_supervisor_unit uut (.*);

  hold_supervisor_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("goal_hold_supervisor_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int spread(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic int pick_reg(input int top, lo, hi);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(hi, lo);
  endfunction

  task automatic send(input logic [2:0] act, input int px, py, hd, lin, ang, input logic ok);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pos_x <= px[PW-1:0];
    in_pos_y <= py[PW-1:0];
    in_heading <= hd[15:0];
    in_linear_speed <= lin[15:0];
    in_turn_rate <= ang[15:0];
    in_switch_ok <= ok;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // hold off the sender until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic load_config(input int a, h, s, d, st);
    logic [CFG_IDX_W-1:0] idx[5];
    int vals[5];
    int i;
    idx = '{REG_ARRIVE_DIST, REG_ARRIVE_HEAD, REG_STOP_SPEED, REG_DRIFT_LIMIT, REG_SETTLE};
    vals = '{a, h, s, d, st};
    for (i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i][CFG_DATA_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    set_arrive = a;
    set_head = h;
    set_stop = s;
    set_drift = d;
    set_settle = st;
  endtask

  // new goal, vehicle settles near it, then ticks, commands, acks, wobble, goal nudges and unused action codes
  task automatic hold_episode();
    int steps, pick, reach, rest_x, rest_y;
    goal_x = spread(8388607);
    goal_y = spread(8388607);
    goal_yaw = spread(32767);
    send(ACT_GOAL, goal_x, goal_y, goal_yaw, $urandom, $urandom, 1'($urandom));
    reach = ($urandom_range(4) == 0) ? 3 : 1;
    rest_x = goal_x + spread(reach * set_arrive / 2);
    rest_y = goal_y + spread(reach * set_arrive / 2);
    send(ACT_ODOM, rest_x, rest_y, goal_yaw + spread(reach * set_head / 2),
         spread(reach * set_stop / 2), $urandom, 1'($urandom));
    steps = $urandom_range(16, 4) + ((set_settle < 12) ? set_settle : 12);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
      end else if (pick < 55) begin
        send(ACT_ACK, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom_range(9) != 0);
      end else if (pick < 70) begin
        send(ACT_CMD, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
      end else if (pick < 85) begin
        // wobble about the resting point, now and then past the drift limit
        reach = ($urandom_range(3) == 0) ? 3 : 1;
        send(ACT_ODOM, rest_x + spread(reach * set_drift / 2),
             rest_y + spread(reach * set_drift / 2), goal_yaw + spread(set_head / 2),
             spread(set_stop / 2), $urandom, 1'($urandom));
      end else if (pick < 95) begin
        send(ACT_GOAL, goal_x + spread(120), goal_y + spread(120), goal_yaw + spread(1100),
             $urandom, $urandom, 1'($urandom));
      end else begin
        send(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom, $urandom,
             1'($urandom));
      end
    end
  endtask

  initial begin
    int phase, seg, stop_at;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_action = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_heading = '0;
    in_linear_speed = '0;
    in_turn_rate = '0;
    in_switch_ok = 1'b0;
    items_sent = 0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    set_arrive = 205;
    set_head = 1565;
    set_stop = 51;
    set_drift = 256;
    set_settle = 20;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults first
    send(3'd5, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    send(3'd7, $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom));
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);                  // no goal yet
    send(ACT_ACK, 0, 0, 0, 0, 0, 1'b1);                   // nothing pending
    send(ACT_CMD, 0, 0, 0, 32767, -32768, 1'b0);
    send(ACT_CMD, -1, -1, -1, -32768, 32767, 1'b1);
    send(ACT_ODOM, -8388608, 8388607, -32768, -32768, 0, 1'b0);
    send(ACT_GOAL, 8388607, -8388608, 32767, 0, 0, 1'b0);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);                  // far away
    // heading error wraps from a full turn down to one unit
    send(ACT_ODOM, 8388507, -8388508, -32768, 50, 0, 1'b0);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);
    send(ACT_CMD, 0, 0, 0, 1000, -1000, 1'b0);
    // just inside both goal-change thresholds
    send(ACT_GOAL, 8388557, -8388608, 31724, 0, 0, 1'b0);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);
    drain();
    load_config(65535, 32767, 32767, 0, 0);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);                  // stop request
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);                  // already pending
    send(ACT_ACK, 0, 0, 0, 0, 0, 1'b0);                   // failed switch
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);
    send(ACT_ACK, 0, 0, 0, 0, 0, 1'b1);
    send(ACT_ODOM, 8388508, -8388508, -32768, 0, 0, 1'b0);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);                  // drift ends hold
    send(ACT_ACK, 0, 0, 0, 0, 0, 1'b1);
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);
    send(ACT_GOAL, 8388607, -8388608, 31723, 0, 0, 1'b0); // yaw change makes it new
    send(ACT_ODOM, 8388607, -8388608, -1045, 0, 0, 1'b0); // half-turn heading error
    send(ACT_TICK, 0, 0, 0, 0, 0, 1'b0);
    send(ACT_CMD, 0, 0, 0, 5, -5, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      recv_idle_pct = RECV_IDLE[phase];
      for (seg = 0; seg < SEGMENTS; seg++) begin
        drain();
        load_config(pick_reg(65535, 50, 1500), pick_reg(32767, 300, 6000),
                    pick_reg(32767, 10, 400), pick_reg(65535, 50, 1500),
                    pick_reg(65535, 0, 6));
        stop_at = items_sent + RANDOM_ITEMS / (3 * SEGMENTS);
        while (items_sent < stop_at) begin
          if ($urandom_range(3) != 0) begin
            hold_episode();
          end else begin
            send(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom, $urandom,
                 1'($urandom));
          end
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("goal_hold_supervisor_unit test passed");
    end else begin
      $display("goal_hold_supervisor_unit test failed");
    end
    $finish;
  end

endmodule
